// File: rtl/tea_pkg.sv
// shared types, constants and round function of the tea block cipher
package tea_pkg;

   typedef logic [31:0] word_type;

   localparam word_type DELTA = 32'h9e37_79b9;

   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // key register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_0_IDX = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_1_IDX = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_2_IDX = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_3_IDX = 2'd3;

   // command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      word_type k0;
      word_type k1;
      word_type k2;
      word_type k3;
   } key_set_type;

   typedef struct packed {
      logic     valid;
      logic     cmd;
      word_type a;
      word_type b;
   } stage_type;

   // running sum seen by a round, only evaluated at elaboration
   function automatic word_type delta_times(input int unsigned n);
      logic [63:0] prod;
      prod = 64'(DELTA) * 64'(n);
      return prod[31:0];
   endfunction

   function automatic word_type tea_mix(input word_type x, input word_type s,
                                        input word_type ka, input word_type kb);
      return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
   endfunction

endpackage

// File: rtl/tea_block_cipher.sv
// top level of the pipelined tea block cipher
//
// TEA encrypt/decrypt engine built as a chain of 2*ROUNDS half-round cells, one register
// each. An item is taken at every clock edge where start is high and busy is low, so a new
// block can enter every cycle; busy is only high during reset and up to the first edge
// after it. The result appears on rsp_result_first/rsp_result_second with rsp_strobe high
// for one cycle, once the item has passed through every cell of the chain. Results come
// out in input order and cannot be held off. Key words are written through the csr port
// and must only change while no item is in the chain.
module tea_block_cipher #(
   parameter int unsigned ROUNDS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  tea_pkg::word_type                    req_word_first,
   input  tea_pkg::word_type                    req_word_second,
   output logic                                 rsp_strobe,
   output tea_pkg::word_type                    rsp_result_first,
   output tea_pkg::word_type                    rsp_result_second,
   input  logic                                 csr_write_enable,
   input  logic [tea_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  tea_pkg::word_type                    csr_write_data
);
   import tea_pkg::*;

   localparam int unsigned NUM_CELLS = 2 * ROUNDS;
   localparam int unsigned LAT_TAIL  = NUM_CELLS - 1;

   key_set_type key_ff, key_in;
   logic        busy_ff;
   stage_type   stage [NUM_CELLS+1];

   // key registers
   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            KEY_WORD_0_IDX: key_in.k0 = csr_write_data;
            KEY_WORD_1_IDX: key_in.k1 = csr_write_data;
            KEY_WORD_2_IDX: key_in.k2 = csr_write_data;
            KEY_WORD_3_IDX: key_in.k3 = csr_write_data;
            default:        key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         key_ff  <= key_in;
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   assign stage[0] = '{valid: start && !busy_ff,
                       cmd:   req_command,
                       a:     req_word_first,
                       b:     req_word_second};

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam int unsigned RIDX = i / 2;
      localparam bit          HALF = (i % 2) == 1;
      tea_round_cell #(
         .ROUNDS      (ROUNDS),
         .ROUND_IDX   (RIDX),
         .SECOND_HALF (HALF)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .key        (key_ff),
         .up_stage   (stage[i]),
         .down_stage (stage[i+1])
      );
   end

   assign rsp_strobe        = stage[NUM_CELLS].valid;
   assign rsp_result_first  = stage[NUM_CELLS].a;
   assign rsp_result_second = stage[NUM_CELLS].b;

   // an accepted item enters the first cell with its command
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (stage[1].valid && stage[1].cmd == $past(req_command)))
      else $error("accepted item missing from first cell");

   // an item in the first cell leaves as a result after the rest of the chain
   a_chain_latency: assert property (@(posedge clock) disable iff (reset)
      stage[1].valid |-> ##LAT_TAIL rsp_strobe)
      else $error("item lost in the cell chain");

   // no result without an item having entered the chain
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!stage[1].valid) |-> ##LAT_TAIL (!rsp_strobe))
      else $error("result strobe without an item");

endmodule

// File: rtl/tea_round_cell.sv
// one half-round of the tea feistel network, registered
module tea_round_cell #(
   parameter int unsigned ROUNDS      = 32,
   parameter int unsigned ROUND_IDX   = 0,
   parameter bit          SECOND_HALF = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tea_pkg::key_set_type key,
   input  tea_pkg::stage_type   up_stage,
   output tea_pkg::stage_type   down_stage
);
   import tea_pkg::*;

   localparam word_type SUM_ENC = delta_times(ROUND_IDX + 1);
   localparam word_type SUM_DEC = delta_times(ROUNDS - ROUND_IDX);

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;
   word_type  sum;
   word_type  mix_x;
   word_type  mix_ka;
   word_type  mix_kb;
   word_type  mix_val;
   logic      is_dec;
   logic      update_a;

   assign is_dec = (up_stage.cmd == CMD_DECRYPT);
   assign sum    = is_dec ? SUM_DEC : SUM_ENC;

   // encrypt updates a then b, decrypt walks back b then a
   assign update_a = (SECOND_HALF == is_dec);

   always_comb begin
      if (update_a) begin
         mix_x  = up_stage.b;
         mix_ka = key.k0;
         mix_kb = key.k1;
      end else begin
         mix_x  = up_stage.a;
         mix_ka = key.k2;
         mix_kb = key.k3;
      end
   end

   assign mix_val = tea_mix(mix_x, sum, mix_ka, mix_kb);

   always_comb begin
      data_in       = up_stage;
      data_in.valid = 1'b0;
      if (update_a) begin
         data_in.a = is_dec ? (up_stage.a - mix_val) : (up_stage.a + mix_val);
      end else begin
         data_in.b = is_dec ? (up_stage.b - mix_val) : (up_stage.b + mix_val);
      end
   end

   assign valid_in = up_stage.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      down_stage       = data_ff;
      down_stage.valid = valid_ff;
   end

endmodule
